/* src/hlsc_pkg.sv */
// Shared types and codes for the held-lock stack checker.
`default_nettype none
package hlsc_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int ID_W    = 32;
    localparam int CLASS_W = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int HCNT_W  = 5;
    localparam int MSLOT_W = 4;

    localparam logic [OP_W-1:0] OP_ACQUIRE     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE     = 2'd1;
    localparam logic [OP_W-1:0] OP_ASSERT_NONE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INACTIVE  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RECURSIVE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_HELD  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_HELD      = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [ID_W-1:0]    lock_id;
        logic [CLASS_W-1:0] class_id;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [HCNT_W-1:0]  held_count;
        logic [MSLOT_W-1:0] match_slot;
        logic               checking_active;
    } result_t;

    // Broadcast to every stack cell
    typedef struct packed {
        logic               cmp_en;
        logic               is_release;
        logic [ID_W-1:0]    key_id;
        logic [CLASS_W-1:0] key_cls;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/hlsc_item_if.sv */
// Lock event input channel.
`default_nettype none
interface hlsc_item_if;
    logic                 valid;
    logic                 ready;
    hlsc_pkg::item_t      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/hlsc_result_if.sv */
// Check result output channel.
`default_nettype none
interface hlsc_result_if;
    logic                 valid;
    logic                 ready;
    hlsc_pkg::result_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/hlsc_cfg_if.sv */
// Configuration write channel for the checking enable bit.
`default_nettype none
interface hlsc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/hlsc_cell.sv */
// One stack slot: holds a lock id and class, compares, pushes and shifts down.
`default_nettype none
module hlsc_cell (
    input  wire logic                         clk,
    input  wire hlsc_pkg::cell_ctrl_t         ctrl,
    input  wire logic                         occ,
    input  wire logic                         push_en,
    input  wire logic                         shift_en,
    input  wire logic [hlsc_pkg::ID_W-1:0]    nbr_id,
    input  wire logic [hlsc_pkg::CLASS_W-1:0] nbr_cls,
    output logic      [hlsc_pkg::ID_W-1:0]    id,
    output logic      [hlsc_pkg::CLASS_W-1:0] cls,
    output logic                              match
);
    import hlsc_pkg::*;

    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic [CLASS_W-1:0] cls_reg;
    logic [CLASS_W-1:0] cls_next;
    logic               match_reg;
    logic               match_next;

    always_comb
    begin
        id_next  = id_reg;
        cls_next = cls_reg;
        // take the upper neighbor's entry on removal, the new key on push
        if (shift_en)
        begin
            id_next  = nbr_id;
            cls_next = nbr_cls;
        end
        else if (push_en)
        begin
            id_next  = ctrl.key_id;
            cls_next = ctrl.key_cls;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            if (ctrl.is_release)
                match_next = occ && (id_reg == ctrl.key_id);
            else
                match_next = occ && (cls_reg == ctrl.key_cls);
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        cls_reg   <= cls_next;
        match_reg <= match_next;
    end

    assign id    = id_reg;
    assign cls   = cls_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

/* src/held_lock_stack_checker_core.sv */
// Held-lock stack checker: top level with sequencer and row of stack cells.
//
// Usage: each transfer on item carries one lock event (acquire, release or
// assert-none) and produces exactly one transfer on result with a status,
// the held count after the event, the matching slot and whether checking
// is still active. cfg writes the checking enable bit and is always ready.
// It is to be written only while no item is in flight; the block does not
// enforce this, so the user must keep to it.
// Sequence: an accepted item is loaded into a register, then every cell
// compares its entry and registers a match bit, then the lowest match is
// picked and all cells push or shift at once. No new item is taken until
// the last one has finished its update. The result sits in an output
// register; a stalled receiver holds it there and the next item is still
// taken, but its update waits until the register frees up.
// Reset: the stack is empty, the checker is not tripped and checking is
// off, so items are reported as ignored until cfg enables it. A trip holds
// until the next reset.
`default_nettype none
module held_lock_stack_checker_core #(
    parameter int STACK_DEPTH = hlsc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hlsc_item_if.sink    item,
    hlsc_result_if.source result,
    hlsc_cfg_if.sink     cfg
);
    import hlsc_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W = $clog2(STACK_DEPTH);

    state_t state_reg;
    state_t state_next;

    logic               checking_on_reg;
    logic               checking_on_next;
    logic               tripped_reg;
    logic               tripped_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    item_t              cur_reg;
    item_t              cur_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_data_reg;
    result_t            out_data_next;

    logic               out_free;
    logic               accept;
    logic               cmp_en;
    logic               upd_en;
    logic               do_push;
    logic               do_remove;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [STAT_W-1:0]  status;
    logic               active;
    logic [CNT_W+HCNT_W-1:0]   count_ext;
    logic [SLOT_W+MSLOT_W-1:0] slot_ext;

    cell_ctrl_t         cell_ctrl;
    logic [STACK_DEPTH-1:0] match_vec;
    logic [STACK_DEPTH-1:0] occ_vec;
    logic [STACK_DEPTH-1:0] push_vec;
    logic [STACK_DEPTH-1:0] shift_vec;
    logic [ID_W-1:0]    cell_id  [STACK_DEPTH];
    logic [CLASS_W-1:0] cell_cls [STACK_DEPTH];

    assign out_free = !out_valid_reg || result.ready;
    assign accept   = item.valid && item.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_COMPARE;
            S_COMPARE:
                state_next = S_UPDATE;
            S_UPDATE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item.ready = 1'b0;
        cmp_en     = 1'b0;
        upd_en     = 1'b0;
        case (state_reg)
            S_IDLE:    item.ready = 1'b1;
            S_COMPARE: cmp_en     = 1'b1;
            S_UPDATE:  upd_en     = out_free;
            default:   item.ready = 1'b0;
        endcase
    end

    assign cfg.ready = 1'b1;

    assign cur_next = accept ? item.data : cur_reg;

    assign cell_ctrl.cmp_en     = cmp_en;
    assign cell_ctrl.is_release = (cur_reg.opcode == OP_RELEASE);
    assign cell_ctrl.key_id     = cur_reg.lock_id;
    assign cell_ctrl.key_cls    = cur_reg.class_id;

    // lowest matching slot
    always_comb
    begin
        slot = '0;
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                slot = SLOT_W'(i);
        end
    end

    assign found  = |match_vec;
    assign active = checking_on_reg && !tripped_reg;

    always_comb
    begin
        status       = STAT_OK;
        tripped_next = tripped_reg;
        count_next   = count_reg;
        do_push      = 1'b0;
        do_remove    = 1'b0;
        if (!active)
        begin
            status = STAT_INACTIVE;
        end
        else
        begin
            case (cur_reg.opcode)
                OP_ACQUIRE:
                    if (found)
                    begin
                        status       = STAT_RECURSIVE;
                        tripped_next = 1'b1;
                    end
                    else if (count_reg >= CNT_W'(STACK_DEPTH))
                    begin
                        status       = STAT_OVERFLOW;
                        tripped_next = 1'b1;
                    end
                    else
                    begin
                        do_push    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                OP_RELEASE:
                    if (found)
                    begin
                        do_remove  = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status       = STAT_NOT_HELD;
                        tripped_next = 1'b1;
                    end
                OP_ASSERT_NONE:
                    if (count_reg != '0)
                    begin
                        status       = STAT_HELD;
                        tripped_next = 1'b1;
                    end
                default:
                    status = STAT_OK;
            endcase
        end
    end

    assign count_ext = {{HCNT_W{1'b0}}, count_next};
    assign slot_ext  = {{MSLOT_W{1'b0}}, slot};

    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (upd_en)
        begin
            out_valid_next             = 1'b1;
            out_data_next.status       = status;
            out_data_next.held_count   = count_ext[HCNT_W-1:0];
            out_data_next.match_slot   = (status == STAT_RECURSIVE || (do_remove))
                                         ? slot_ext[MSLOT_W-1:0] : '0;
            out_data_next.checking_active = checking_on_reg && !tripped_next;
        end
    end

    assign checking_on_next = (cfg.valid && cfg.ready) ? cfg.data : checking_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            checking_on_reg <= 1'b0;
            tripped_reg     <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            checking_on_reg <= checking_on_next;
            out_valid_reg   <= out_valid_next;
            if (upd_en)
            begin
                tripped_reg <= tripped_next;
                count_reg   <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // row of stack cells; each shifts from its upper neighbor
    for (genvar g = 0; g < STACK_DEPTH; g++)
    begin : g_cell
        logic [ID_W-1:0]    nbr_id;
        logic [CLASS_W-1:0] nbr_cls;

        assign occ_vec[g]   = (CNT_W'(g) < count_reg);
        assign push_vec[g]  = upd_en && do_push && (count_reg == CNT_W'(g));
        assign shift_vec[g] = upd_en && do_remove && (SLOT_W'(g) >= slot);

        if (g == STACK_DEPTH - 1)
        begin : g_top
            assign nbr_id  = cell_id[g];
            assign nbr_cls = cell_cls[g];
        end
        else
        begin : g_mid
            assign nbr_id  = cell_id[g+1];
            assign nbr_cls = cell_cls[g+1];
        end

        hlsc_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .occ      (occ_vec[g]),
            .push_en  (push_vec[g]),
            .shift_en (shift_vec[g]),
            .nbr_id   (nbr_id),
            .nbr_cls  (nbr_cls),
            .id       (cell_id[g]),
            .cls      (cell_cls[g]),
            .match    (match_vec[g])
        );
    end

endmodule
`default_nettype wire

/* src/hlsc_checker.sv */
// Port-level assertions for the held-lock stack checker, bound to the top level.
`default_nettype none
module hlsc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            item_valid,
    input wire logic                            item_ready,
    input wire logic                            result_valid,
    input wire logic                            result_ready,
    input wire logic [hlsc_pkg::STAT_W-1:0]     status,
    input wire logic [hlsc_pkg::MSLOT_W-1:0]    match_slot,
    input wire logic                            checking_active
);
    import hlsc_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
        && $stable(match_slot) && $stable(checking_active))
        else $error("result changed while stalled");

    // one item in flight: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status <= STAT_HELD)
        else $error("status code out of range");

    // every error trips the checker; an ignored item also reports it inactive
    a_error_trips: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STAT_RECURSIVE || status == STAT_OVERFLOW
        || status == STAT_NOT_HELD || status == STAT_HELD || status == STAT_INACTIVE)
        |-> !checking_active)
        else $error("checker still active after error or ignored item");

    a_inactive_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STAT_INACTIVE |-> match_slot == '0)
        else $error("ignored item reported a slot");

endmodule

bind held_lock_stack_checker_core hlsc_checker u_hlsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .status          (result.data.status),
    .match_slot      (result.data.match_slot),
    .checking_active (result.data.checking_active)
);
`default_nettype wire

/* sim/held_lock_stack_checker_core_monitor.sv */
// Scoreboard for the held-lock stack checker: shadow stack, expected results and compare.
`timescale 1ns / 100ps
module held_lock_stack_checker_core_monitor (
    input  logic   clk,
    input  logic   rst_n,
    hlsc_item_if   item,
    hlsc_result_if result,
    hlsc_cfg_if    cfg,
    output int     fail_count,
    output int     results_seen
);
    import hlsc_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    logic [ID_W-1:0]    shadow_ids [DEPTH];
    logic [CLASS_W-1:0] shadow_cls [DEPTH];
    int                 shadow_depth;
    logic               shadow_tripped;
    logic               shadow_enabled;
    result_t            expected_results [$];
    int                 mismatches;
    int                 seen;

    assign fail_count   = mismatches;
    assign results_seen = seen;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Apply one lock event to the shadow stack and work out its result.
    task automatic predict_lock_event(input item_t ev, output result_t res);
        int hit;
        hit = -1;
        res.status     = STAT_OK;
        res.match_slot = '0;
        if (!shadow_enabled || shadow_tripped)
            res.status = STAT_INACTIVE;
        else if (ev.opcode == OP_ACQUIRE)
        begin
            for (int i = 0; i < shadow_depth; i++)
                if (hit < 0 && shadow_cls[i] == ev.class_id)
                    hit = i;
            if (hit >= 0)
            begin
                res.status     = STAT_RECURSIVE;
                res.match_slot = MSLOT_W'(hit);
                shadow_tripped = 1'b1;
            end
            else if (shadow_depth >= DEPTH)
            begin
                res.status     = STAT_OVERFLOW;
                shadow_tripped = 1'b1;
            end
            else
            begin
                shadow_ids[shadow_depth] = ev.lock_id;
                shadow_cls[shadow_depth] = ev.class_id;
                shadow_depth++;
            end
        end
        else if (ev.opcode == OP_RELEASE)
        begin
            for (int i = 0; i < shadow_depth; i++)
                if (hit < 0 && shadow_ids[i] == ev.lock_id)
                    hit = i;
            if (hit >= 0)
            begin
                res.match_slot = MSLOT_W'(hit);
                // shift whole entries down over the removed slot
                for (int i = hit; i + 1 < shadow_depth; i++)
                begin
                    shadow_ids[i] = shadow_ids[i + 1];
                    shadow_cls[i] = shadow_cls[i + 1];
                end
                shadow_depth--;
            end
            else
            begin
                res.status     = STAT_NOT_HELD;
                shadow_tripped = 1'b1;
            end
        end
        else if (ev.opcode == OP_ASSERT_NONE)
        begin
            if (shadow_depth != 0)
            begin
                res.status     = STAT_HELD;
                shadow_tripped = 1'b1;
            end
        end
        res.held_count      = HCNT_W'(shadow_depth);
        res.checking_active = shadow_enabled && !shadow_tripped;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next_want;
        if (!rst_n)
        begin
            shadow_depth   = 0;
            shadow_tripped = 1'b0;
            shadow_enabled = 1'b0;
            expected_results.delete();
            mismatches     = 0;
            seen           = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                shadow_enabled = cfg.data;
            // compare before queuing: a result can never belong to this edge's event
            if (result.valid && result.ready)
            begin
                seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with no event outstanding, status %0d",
                                              result.data.status));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(result.data.status), 32'(want.status));
                    check_field("held_count", 32'(result.data.held_count),
                                32'(want.held_count));
                    check_field("match_slot", 32'(result.data.match_slot),
                                32'(want.match_slot));
                    check_field("checking_active", 32'(result.data.checking_active),
                                32'(want.checking_active));
                end
            end
            if (item.valid && item.ready)
            begin
                predict_lock_event(item.data, next_want);
                expected_results.push_back(next_want);
            end
        end
    end

endmodule

/* sim/held_lock_stack_checker_core_test.sv */
// Testbench top for the held-lock stack checker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module held_lock_stack_checker_core_test;
    import hlsc_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int DEPTH           = STACK_DEPTH_DEF;
    localparam int RANDOM_EVENTS   = 600;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int IDLE_PCT        = 24;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;

    typedef enum {TRIP_RECURSIVE, TRIP_OVERFLOW, TRIP_NOT_HELD, TRIP_HELD} trip_kind_t;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [CLASS_W-1:0] cls;
    } held_lock_t;

    logic          clk = 1'b0;
    logic          rst_n;
    hlsc_item_if   item_ch ();
    hlsc_result_if result_ch ();
    hlsc_cfg_if    cfg_ch ();

    int         fail_count;
    int         results_seen;
    int         events_sent = 0;
    int         cycles = 0;
    int         hold_requests = 0;
    int         max_held = 0;
    bit         calm = 1'b0;
    bit         live = 1'b0;
    bit         tripped = 1'b0;
    held_lock_t held_q [$];
    trip_kind_t trip_kind;

    always #5 clk = ~clk;

    held_lock_stack_checker_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    held_lock_stack_checker_core_monitor mon (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .cfg          (cfg_ch),
        .fail_count   (fail_count),
        .results_seen (results_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycles, results_seen, events_sent);
            $display("held_lock_stack_checker_core regression: fail");
            $finish;
        end
    end

    // Result receiver: random stalls, a calm stretch, and requested long hold-offs.
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic bit class_held(input logic [CLASS_W-1:0] c);
        foreach (held_q[k])
            if (held_q[k].cls == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit id_held(input logic [ID_W-1:0] id);
        foreach (held_q[k])
            if (held_q[k].id == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [CLASS_W-1:0] unused_class();
        logic [CLASS_W-1:0] c;
        do
            c = CLASS_W'($urandom());
        while (class_held(c));
        return c;
    endfunction

    function automatic logic [ID_W-1:0] unheld_id();
        logic [ID_W-1:0] id;
        do
            id = $urandom();
        while (id_held(id));
        return id;
    endfunction

    // Offer one event until it transfers; track the held set while checking is live.
    task automatic send_event(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [CLASS_W-1:0] cls);
        item_t ev;
        int    slot;
        ev.opcode   = op;
        ev.lock_id  = id;
        ev.class_id = cls;
        slot        = -1;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= ev;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        events_sent++;
        if (live)
        begin
            if (op == OP_ACQUIRE && !class_held(cls) && held_q.size() < DEPTH)
                held_q.push_back('{id, cls});
            else if (op == OP_RELEASE)
            begin
                foreach (held_q[k])
                    if (slot < 0 && held_q[k].id == id)
                        slot = k;
                if (slot >= 0)
                    held_q.delete(slot);
            end
            if (held_q.size() > max_held)
                max_held = held_q.size();
        end
    endtask

    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_seen < events_sent)
            @(posedge clk);
    endtask

    task automatic write_checking(input logic on);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= on;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        live = on && !tripped;
    endtask

    // Acquire under a class not yet held; sometimes reuse a held lock id.
    task automatic acquire_fresh();
        logic [ID_W-1:0] id;
        if (held_q.size() > 0 && $urandom_range(0, 4) == 0)
            id = held_q[$urandom_range(0, held_q.size() - 1)].id;
        else
            id = $urandom();
        send_event(OP_ACQUIRE, id, unused_class());
    endtask

    task automatic raw_event();
        send_event(OP_W'($urandom_range(0, 3)), $urandom(), CLASS_W'($urandom()));
    endtask

    // Well-formed traffic with a little noise; fill_bias leans toward acquires.
    task automatic random_event(input bit fill_bias);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            if (held_q.size() == 0 && roll < 4)
                send_event(OP_ASSERT_NONE, $urandom(), CLASS_W'($urandom()));
            else
                send_event(OP_NOP, $urandom(), CLASS_W'($urandom()));
        end
        else if (held_q.size() < DEPTH && (held_q.size() == 0 ||
                 $urandom_range(0, 99) < (fill_bias ? 75 : 30)))
            acquire_fresh();
        else
            send_event(OP_RELEASE, held_q[$urandom_range(0, held_q.size() - 1)].id,
                       CLASS_W'($urandom()));
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // checking off after reset: everything is ignored, opcode three too
        send_event(OP_ACQUIRE, '1, '1);
        send_event(OP_RELEASE, '0, '0);
        send_event(OP_ASSERT_NONE, 32'h5555_AAAA, 16'hA5A5);
        send_event(OP_NOP, '1, '1);

        write_checking(1'b1);
        send_event(OP_ASSERT_NONE, '0, '0);
        send_event(OP_NOP, '0, '0);
        send_event(OP_ACQUIRE, '0, '0);
        send_event(OP_ACQUIRE, '1, '1);
        send_event(OP_ACQUIRE, 32'h1234_5678, 16'h0001);
        // same lock id as slot 0 under another class: release takes the lowest
        send_event(OP_ACQUIRE, '0, 16'h8000);
        send_event(OP_RELEASE, '0, '1);
        send_event(OP_RELEASE, '0, '0);
        send_event(OP_RELEASE, '1, '0);
        send_event(OP_RELEASE, 32'h1234_5678, '0);
        send_event(OP_ASSERT_NONE, '0, '0);

        write_checking(1'b0);
        send_event(OP_ACQUIRE, 32'hDEAD_0001, 16'h0002);
        send_event(OP_ASSERT_NONE, '0, '0);
        write_checking(1'b1);

        for (int i = 0; i < RANDOM_EVENTS; i++)
        begin
            // hold off the receiver while events keep coming
            if (i == 100)
                hold_requests++;
            if (i == 250)
                wait_for_results();
            if (i == 400)
                calm = 1'b1;
            if (i == 500)
                calm = 1'b0;
            if (i % 150 == 149)
            begin
                write_checking(1'b0);
                repeat (6) raw_event();
                write_checking(1'b1);
            end
            random_event((i / 40) % 2 == 0);
        end

        // one trip per run: pick its kind at random
        wait_for_results();
        trip_kind = trip_kind_t'($urandom_range(0, 3));
        case (trip_kind)
            TRIP_RECURSIVE:
            begin
                if (held_q.size() == 0)
                    acquire_fresh();
                send_event(OP_ACQUIRE, $urandom(),
                           held_q[$urandom_range(0, held_q.size() - 1)].cls);
            end
            TRIP_OVERFLOW:
            begin
                while (held_q.size() < DEPTH)
                    acquire_fresh();
                send_event(OP_ACQUIRE, $urandom(), unused_class());
            end
            TRIP_NOT_HELD:
                send_event(OP_RELEASE, unheld_id(), CLASS_W'($urandom()));
            default:
            begin
                if (held_q.size() == 0)
                    acquire_fresh();
                send_event(OP_ASSERT_NONE, $urandom(), CLASS_W'($urandom()));
            end
        endcase
        tripped = 1'b1;
        live    = 1'b0;

        repeat (30) raw_event();
        // enabling again must not clear the trip
        write_checking(1'b1);
        repeat (8) raw_event();

        wait_for_results();
        repeat (10) @(posedge clk);
        $display("covered %0d lock events: directed cases, %0d random events with up to %0d held",
                 events_sent, RANDOM_EVENTS, max_held);
        $display("ended with a %s trip; %0d results compared, %0d mismatches",
                 trip_kind.name(), results_seen, fail_count);
        if (fail_count == 0)
            $display("held_lock_stack_checker_core regression: pass");
        else
            $display("held_lock_stack_checker_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
src/hlsc_pkg.sv
src/hlsc_item_if.sv
src/hlsc_result_if.sv
src/hlsc_cfg_if.sv
src/hlsc_cell.sv
src/held_lock_stack_checker_core.sv
src/hlsc_checker.sv
sim/held_lock_stack_checker_core_monitor.sv
sim/held_lock_stack_checker_core_test.sv
